[hw/rtl/fat_chain_read_mapper_unit_macros.svh]
// assertion helpers for the chain read mapper checker
`ifndef FAT_CHAIN_READ_MAPPER_UNIT_MACROS_SVH
`define FAT_CHAIN_READ_MAPPER_UNIT_MACROS_SVH

// same-cycle implication
`define FCRM_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("fcrm check failed");

// next-cycle implication
`define FCRM_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("fcrm check failed");

`endif

[hw/rtl/fcrm_pkg.sv]
package fcrm_pkg;

  localparam int BLOCK_BYTES_DEF  = 4096;
  localparam int DIR_SLOTS_DEF    = 256;
  localparam int DISK_BLOCKS_DEF  = 1024;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam int NAME_BYTES = 6;
  localparam logic [9:0] END_MARK = 10'd1;

  localparam logic [1:0] FUNC_CHAIN = 2'd0;
  localparam logic [1:0] FUNC_DIR   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] ST_SEGMENT    = 3'd0;
  localparam logic [2:0] ST_NOTHING    = 3'd1;
  localparam logic [2:0] ST_UNMOUNTED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

  typedef struct packed {
    logic        used;
    logic [47:0] name;
    logic [22:0] size;
    logic [9:0]  first;
  } dir_ent_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_FOUND,
    S_SKIP,
    S_SKIP_W,
    S_SEG,
    S_SEG_W,
    S_RESULT
  } state_t;

  // byte-wise compare up to and including the first zero byte
  function automatic logic names_match(input logic [47:0] a, input logic [47:0] b);
    logic ok;
    logic stop;
    ok = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!stop) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          ok = 1'b0;
          stop = 1'b1;
        end else if (a[8*i +: 8] == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

[hw/rtl/fcrm_chan_if.sv]
interface fcrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  entry_index;
  logic [9:0]  chain_next;
  logic        slot_used;
  logic [47:0] file_name;
  logic [22:0] file_size;
  logic [9:0]  start_block;
  logic [22:0] read_length;
  logic [22:0] read_offset;

  modport source (output valid, func, entry_index, chain_next, slot_used, file_name,
                  file_size, start_block, read_length, read_offset, input ready);
  modport sink (input valid, func, entry_index, chain_next, slot_used, file_name,
                file_size, start_block, read_length, read_offset, output ready);
endinterface

interface fcrm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  block_number;
  logic [11:0] block_start;
  logic [12:0] byte_count;
  logic [22:0] dest_offset;
  logic [22:0] total_read;
  logic        last;

  modport source (output valid, status, block_number, block_start, byte_count,
                  dest_offset, total_read, last, input ready);
  modport sink (input valid, status, block_number, block_start, byte_count,
                dest_offset, total_read, last, output ready);
endinterface

[hw/rtl/fat_chain_read_mapper_unit.sv]
// a load is written as it is accepted; a read request scans the directory slot by slot,
//   then walks the chain past the skipped blocks and emits one segment per block read
// throughput: one request at a time, bounded by the single read port of the
//   directory and chain memories (one slot per cycle while searching)
// reset: synchronous active low; a clearing pass then marks every directory slot
//   unused, requests are held off until it ends
module fat_chain_read_mapper_unit #(
  parameter int BLOCK_BYTES  = fcrm_pkg::BLOCK_BYTES_DEF,
  parameter int DIR_SLOTS    = fcrm_pkg::DIR_SLOTS_DEF,
  parameter int DISK_BLOCKS  = fcrm_pkg::DISK_BLOCKS_DEF,
  parameter int MAX_SEGMENTS = fcrm_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fcrm_in_if.sink     in_req,
  fcrm_out_if.source  out_res,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import fcrm_pkg::*;

  localparam int CAW = $clog2(DISK_BLOCKS);
  localparam int DAW = $clog2(DIR_SLOTS);
  localparam int DCW = $clog2(DIR_SLOTS + 1);
  localparam int BOW = $clog2(BLOCK_BYTES);
  localparam int NW  = $clog2(MAX_SEGMENTS + 1);
  localparam logic [23:0] BB24 = 24'(BLOCK_BYTES);

  // memories
  logic [9:0] chain_mem [DISK_BLOCKS];
  dir_ent_t   dir_mem [DIR_SLOTS];

  logic           chain_we, chain_re;
  logic [CAW-1:0] chain_waddr, chain_raddr;
  logic [9:0]     chain_q_r;
  logic           dir_we;
  logic [DAW-1:0] dir_waddr, dir_raddr;
  dir_ent_t       dir_wdata, dir_q_r;

  // control and working registers
  state_t         state_r, state_nxt;
  logic           mounted_r;
  logic [DAW-1:0] clr_r, clr_nxt;
  logic [DCW-1:0] s_r, s_nxt;
  logic           cmp_pend_r, cmp_pend_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [47:0]    name_r, name_nxt;
  logic [22:0]    len_r, len_nxt;
  logic [22:0]    off_r, off_nxt;
  logic [22:0]    size_r, size_nxt;
  logic [9:0]     blk_r, blk_nxt;
  logic [22:0]    rem_r, rem_nxt;
  logic [BOW-1:0] bofs_r, bofs_nxt;
  logic [22:0]    done_r, done_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic           nxt_ok_r, nxt_ok_nxt;
  logic [2:0]     res_status_r, res_status_nxt;

  logic [2:0]     o_status_r, o_status_nxt;
  logic [9:0]     o_block_r, o_block_nxt;
  logic [11:0]    o_bstart_r, o_bstart_nxt;
  logic [12:0]    o_count_r, o_count_nxt;
  logic [22:0]    o_dest_r, o_dest_nxt;
  logic [22:0]    o_total_r, o_total_nxt;
  logic           o_last_r, o_last_nxt;

  // helpers
  logic        in_fire, out_free, slot_hit;
  logic [31:0] idx32, blk32, bofs32, rem32;
  logic [23:0] sum_ol, room, left, cnt, tot;
  logic [9:0]  link;
  logic        blk_in_range, fin;

  assign in_fire   = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_res.ready;
  assign idx32     = {22'd0, in_req.entry_index};
  assign blk32     = {22'd0, blk_r};
  assign bofs32    = 32'(bofs_r);
  assign rem32     = {9'd0, rem_r};
  assign blk_in_range = blk32 < 32'(DISK_BLOCKS);
  assign slot_hit  = cmp_pend_r && dir_q_r.used && names_match(dir_q_r.name, name_r);

  // offset plus length against the file end
  assign sum_ol = {1'b0, off_r} + {1'b0, len_r};

  // segment sizing: rest of the block against what is still wanted
  assign room = BB24 - 24'(bofs_r);
  assign left = {1'b0, len_r} - {1'b0, done_r};
  assign cnt  = (room < left) ? room : left;
  assign tot  = {1'b0, done_r} + cnt;
  assign link = nxt_ok_r ? chain_q_r : END_MARK;
  assign fin  = (cnt == left) || (link == END_MARK) || (n_r == NW'(MAX_SEGMENTS - 1));

  assign chain_waddr = idx32[CAW-1:0];
  assign chain_raddr = blk32[CAW-1:0];

  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_waddr] <= in_req.chain_next;
    end
    if (chain_re) begin
      chain_q_r <= chain_mem[chain_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_q_r <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mounted_r   <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      if (cfg_we) begin
        mounted_r <= cfg_wdata;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    name_r       <= name_nxt;
    len_r        <= len_nxt;
    off_r        <= off_nxt;
    size_r       <= size_nxt;
    blk_r        <= blk_nxt;
    rem_r        <= rem_nxt;
    bofs_r       <= bofs_nxt;
    done_r       <= done_nxt;
    n_r          <= n_nxt;
    nxt_ok_r     <= nxt_ok_nxt;
    res_status_r <= res_status_nxt;
    o_status_r   <= o_status_nxt;
    o_block_r    <= o_block_nxt;
    o_bstart_r   <= o_bstart_nxt;
    o_count_r    <= o_count_nxt;
    o_dest_r     <= o_dest_nxt;
    o_total_r    <= o_total_nxt;
    o_last_r     <= o_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    s_nxt          = s_r;
    cmp_pend_nxt   = 1'b0;
    name_nxt       = name_r;
    len_nxt        = len_r;
    off_nxt        = off_r;
    size_nxt       = size_r;
    blk_nxt        = blk_r;
    rem_nxt        = rem_r;
    bofs_nxt       = bofs_r;
    done_nxt       = done_r;
    n_nxt          = n_r;
    nxt_ok_nxt     = nxt_ok_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    o_status_nxt   = o_status_r;
    o_block_nxt    = o_block_r;
    o_bstart_nxt   = o_bstart_r;
    o_count_nxt    = o_count_r;
    o_dest_nxt     = o_dest_r;
    o_total_nxt    = o_total_r;
    o_last_nxt     = o_last_r;

    chain_we  = 1'b0;
    chain_re  = 1'b0;
    dir_we    = 1'b0;
    dir_waddr = idx32[DAW-1:0];
    dir_wdata = '{used: in_req.slot_used, name: in_req.file_name,
                  size: in_req.file_size, first: in_req.start_block};
    dir_raddr = s_r[DAW-1:0];
    in_req.ready = 1'b0;

    case (state_r)
      // mark every slot unused after reset
      S_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_r;
        dir_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == DAW'(DIR_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          case (in_req.func)
            FUNC_CHAIN: begin
              chain_we = idx32 < 32'(DISK_BLOCKS);
            end
            FUNC_DIR: begin
              dir_we = idx32 < 32'(DIR_SLOTS);
            end
            FUNC_READ: begin
              name_nxt = in_req.file_name;
              len_nxt  = in_req.read_length;
              off_nxt  = in_req.read_offset;
              s_nxt    = '0;
              if (!mounted_r) begin
                res_status_nxt = ST_UNMOUNTED;
                state_nxt      = S_RESULT;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one slot read per cycle, each compared in the cycle after its read
      S_SEARCH: begin
        if (slot_hit) begin
          size_nxt  = dir_q_r.size;
          blk_nxt   = dir_q_r.first;
          state_nxt = S_FOUND;
        end else if (s_r == DCW'(DIR_SLOTS)) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          cmp_pend_nxt = 1'b1;
          s_nxt        = s_r + 1'b1;
        end
      end

      // offset check and clamp to the file end
      S_FOUND: begin
        rem_nxt = off_r;
        if (off_r > size_r) begin
          res_status_nxt = ST_BAD_OFFSET;
          state_nxt      = S_RESULT;
        end else if (sum_ol > {1'b0, size_r}) begin
          len_nxt = size_r - off_r;
          if (size_r == off_r) begin
            res_status_nxt = ST_NOTHING;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_SKIP;
          end
        end else if (len_r == 23'd0) begin
          res_status_nxt = ST_NOTHING;
          state_nxt      = S_RESULT;
        end else begin
          state_nxt = S_SKIP;
        end
      end

      // walk whole blocks until the offset lies in the current one
      S_SKIP: begin
        if (blk_r == END_MARK) begin
          res_status_nxt = ST_NOTHING;
          state_nxt      = S_RESULT;
        end else if (rem32 >= 32'(BLOCK_BYTES)) begin
          chain_re   = blk_in_range;
          nxt_ok_nxt = blk_in_range;
          state_nxt  = S_SKIP_W;
        end else begin
          bofs_nxt  = rem_r[BOW-1:0];
          done_nxt  = '0;
          n_nxt     = '0;
          state_nxt = S_SEG;
        end
      end

      S_SKIP_W: begin
        blk_nxt   = link;
        rem_nxt   = rem_r - BB24[22:0];
        state_nxt = S_SKIP;
      end

      S_SEG: begin
        chain_re   = blk_in_range;
        nxt_ok_nxt = blk_in_range;
        state_nxt  = S_SEG_W;
      end

      // emit one segment once the output register is free
      S_SEG_W: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_SEGMENT;
          o_block_nxt   = blk_r;
          o_bstart_nxt  = bofs32[11:0];
          o_count_nxt   = cnt[12:0];
          o_dest_nxt    = done_r;
          o_total_nxt   = tot[22:0];
          o_last_nxt    = fin;
          done_nxt      = tot[22:0];
          bofs_nxt      = '0;
          blk_nxt       = link;
          n_nxt         = n_r + 1'b1;
          state_nxt     = fin ? S_IDLE : S_SEG;
        end
      end

      // single error or empty result
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_block_nxt   = '0;
          o_bstart_nxt  = '0;
          o_count_nxt   = '0;
          o_dest_nxt    = '0;
          o_total_nxt   = '0;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = o_status_r;
  assign out_res.block_number = o_block_r;
  assign out_res.block_start  = o_bstart_r;
  assign out_res.byte_count   = o_count_r;
  assign out_res.dest_offset  = o_dest_r;
  assign out_res.total_read   = o_total_r;
  assign out_res.last         = o_last_r;

endmodule

[hw/rtl/fcrm_checker.sv]
`include "fat_chain_read_mapper_unit_macros.svh"

module fcrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [9:0]  block_number,
  input logic [11:0] block_start,
  input logic [12:0] byte_count,
  input logic [22:0] dest_offset,
  input logic [22:0] total_read,
  input logic        last
);
  import fcrm_pkg::*;

  `FCRM_ASSERT_NXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `FCRM_ASSERT_NXT(a_payload_hold, clk, rst_n, out_valid && !out_ready, $stable({status, block_number, block_start, byte_count, dest_offset, total_read, last}))
  `FCRM_ASSERT_IMP(a_error_shape, clk, rst_n, out_valid && status != ST_SEGMENT, last && block_number == 10'd0 && block_start == 12'd0 && byte_count == 13'd0 && dest_offset == 23'd0 && total_read == 23'd0)
  `FCRM_ASSERT_IMP(a_segment_sum, clk, rst_n, out_valid && status == ST_SEGMENT, byte_count != 13'd0 && total_read == dest_offset + 23'(byte_count))

endmodule

bind fat_chain_read_mapper_unit fcrm_checker u_fcrm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .status       (out_res.status),
  .block_number (out_res.block_number),
  .block_start  (out_res.block_start),
  .byte_count   (out_res.byte_count),
  .dest_offset  (out_res.dest_offset),
  .total_read   (out_res.total_read),
  .last         (out_res.last)
);

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fcrm_pkg::*;

  localparam int unsigned BLK_BYTES = BLOCK_BYTES_DEF;
  localparam int unsigned N_SLOTS   = DIR_SLOTS_DEF;
  localparam int unsigned N_BLOCKS  = DISK_BLOCKS_DEF;
  localparam int unsigned SEG_CAP   = MAX_SEGMENTS_DEF;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;   // unused code, block drops it

  // one request as the sender sees it
  typedef struct {
    logic [1:0]  func;
    logic [9:0]  idx;
    logic [9:0]  nxt;
    logic        used;
    logic [47:0] name;
    logic [22:0] size;
    logic [9:0]  first;
    logic [22:0] len;
    logic [22:0] off;
  } req_t;

  // one result as it should leave the block
  typedef struct {
    logic [2:0]  status;
    logic [9:0]  blk;
    logic [11:0] bstart;
    logic [12:0] cnt;
    logic [22:0] dst;
    logic [22:0] tot;
    logic        last;
  } seg_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  fcrm_in_if  req_if ();
  fcrm_out_if res_if ();

  fat_chain_read_mapper_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the tables and the mount flag
  bit [9:0]  fat_link  [N_BLOCKS];
  bit        fat_known [N_BLOCKS];
  bit        dir_used  [N_SLOTS];
  bit [47:0] dir_name  [N_SLOTS];
  bit [22:0] dir_size  [N_SLOTS];
  bit [9:0]  dir_first [N_SLOTS];
  bit        mount_q;

  seg_t segs_due[$];     // segments and error results still to come out

  int mismatches;
  int n_items, n_reads, n_segs, n_errs;
  bit calm;              // no idling on either side while set

  // clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generous overall limit
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", segs_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // six ascii bytes, first character in the low byte, zero padded
  function automatic logic [47:0] pack_name(string s);
    logic [47:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 6; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic bit same_name(logic [47:0] a, logic [47:0] b);
    for (int i = 0; i < 6; i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic seg_t single_status(logic [2:0] st);
    seg_t s;
    s = '{status: st, blk: '0, bstart: '0, cnt: '0, dst: '0, tot: '0, last: 1'b1};
    return s;
  endfunction

  // work out the segments of a read; returns a chain index that would be read
  // while still unwritten, or -1 when the walk only touches known entries
  function automatic int map_read(req_t r, ref seg_t segs[$]);
    int unsigned sz, len, off, blk, nxt, skip, bofs, done, cnt, slot;
    bit found;
    seg_t s;
    segs.delete();
    if (!mount_q) begin
      segs.push_back(single_status(ST_UNMOUNTED));
      return -1;
    end
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      if (!found && dir_used[i] && same_name(dir_name[i], r.name)) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (!found) begin
      segs.push_back(single_status(ST_NOT_FOUND));
      return -1;
    end
    sz  = dir_size[slot];
    len = r.len;
    off = r.off;
    if (off > sz) begin
      segs.push_back(single_status(ST_BAD_OFFSET));
      return -1;
    end
    if (off + len > sz) len = sz - off;
    if (len == 0) begin
      segs.push_back(single_status(ST_NOTHING));
      return -1;
    end
    blk  = dir_first[slot];
    skip = off / BLK_BYTES;
    for (int unsigned i = 0; i < skip; i++) begin
      if (blk == END_MARK) begin
        segs.push_back(single_status(ST_NOTHING));
        return -1;
      end
      if (!fat_known[blk]) return blk;
      blk = fat_link[blk];
    end
    if (blk == END_MARK) begin
      segs.push_back(single_status(ST_NOTHING));
      return -1;
    end
    bofs = off % BLK_BYTES;
    done = 0;
    while (done < len && blk != END_MARK && segs.size() < SEG_CAP) begin
      cnt = BLK_BYTES - bofs;
      if (cnt > len - done) cnt = len - done;
      if (!fat_known[blk]) return blk;
      nxt = fat_link[blk];
      s.status = ST_SEGMENT;
      s.blk    = blk[9:0];
      s.bstart = bofs[11:0];
      s.cnt    = cnt[12:0];
      s.dst    = done[22:0];
      s.tot    = 23'(done + cnt);
      s.last   = (done + cnt >= len) || (nxt == END_MARK) || (segs.size() + 1 >= SEG_CAP);
      segs.push_back(s);
      done += cnt;
      bofs = 0;
      blk  = nxt;
    end
    return -1;
  endfunction

  // hand one request to the block and update the shadow tables on acceptance
  task automatic send_req(req_t r);
    seg_t segs[$];
    while (!calm && $urandom_range(0, 99) < 17) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= r.func;
    req_if.entry_index <= r.idx;
    req_if.chain_next  <= r.nxt;
    req_if.slot_used   <= r.used;
    req_if.file_name   <= r.name;
    req_if.file_size   <= r.size;
    req_if.start_block <= r.first;
    req_if.read_length <= r.len;
    req_if.read_offset <= r.off;
    do @(posedge clk); while (!req_if.ready);
    n_items++;
    case (r.func)
      FUNC_CHAIN: begin
        fat_link[r.idx]  = r.nxt;
        fat_known[r.idx] = 1'b1;
      end
      FUNC_DIR: begin
        if (r.idx < N_SLOTS) begin
          dir_used[r.idx]  = r.used;
          dir_name[r.idx]  = r.name;
          dir_size[r.idx]  = r.size;
          dir_first[r.idx] = r.first;
        end
      end
      FUNC_READ: begin
        void'(map_read(r, segs));
        n_reads++;
        foreach (segs[i]) begin
          segs_due.push_back(segs[i]);
          if (segs[i].status == ST_SEGMENT) n_segs++;
          else n_errs++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_t blank_req(logic [1:0] f);
    req_t r;
    r = '{func: f, idx: '0, nxt: '0, used: 1'b0, name: '0, size: '0, first: '0,
          len: '0, off: '0};
    return r;
  endfunction

  task automatic load_link(int unsigned idx, int unsigned nxt);
    req_t r;
    r = blank_req(FUNC_CHAIN);
    r.idx = idx;
    r.nxt = nxt;
    send_req(r);
  endtask

  task automatic load_slot(int unsigned idx, logic used, logic [47:0] name,
                           int unsigned sz, int unsigned first);
    req_t r;
    r = blank_req(FUNC_DIR);
    r.idx   = idx;
    r.used  = used;
    r.name  = name;
    r.size  = sz;
    r.first = first;
    send_req(r);
  endtask

  // reads are only sent once every chain entry on their walk is written
  task automatic read_file(logic [47:0] name, int unsigned len, int unsigned off);
    req_t r;
    seg_t segs[$];
    int   miss;
    r = blank_req(FUNC_READ);
    r.name = name;
    r.len  = len;
    r.off  = off;
    miss = map_read(r, segs);
    while (miss >= 0) begin
      load_link(miss, ($urandom_range(0, 3) == 0) ? END_MARK : $urandom_range(0, 63));
      miss = map_read(r, segs);
    end
    send_req(r);
  endtask

  // stop sending, wait for all results, then give the block time to settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mount(bit v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mount_q = v;
  endtask

  // results: compare against the oldest expectation
  always @(posedge clk) begin : result_check
    seg_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (segs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected, status %0d", $realtime,
                   res_if.status);
      end else begin
        want = segs_due.pop_front();
        if (res_if.status !== want.status || res_if.block_number !== want.blk ||
            res_if.block_start !== want.bstart || res_if.byte_count !== want.cnt ||
            res_if.dest_offset !== want.dst || res_if.total_read !== want.tot ||
            res_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp st=%0d blk=%0d bs=%0d cnt=%0d dst=%0d tot=%0d last=%0d / got st=%0d blk=%0d bs=%0d cnt=%0d dst=%0d tot=%0d last=%0d",
                     $realtime, want.status, want.blk, want.bstart, want.cnt, want.dst,
                     want.tot, want.last, res_if.status, res_if.block_number,
                     res_if.block_start, res_if.byte_count, res_if.dest_offset,
                     res_if.total_read, res_if.last);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk)
    res_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);

  // reads before mounting, plus an unused code and a load that is dropped
  task automatic test_unmounted();
    req_t r;
    set_mount(1'b0);
    read_file(pack_name("A"), 100, 0);
    r = blank_req(FUNC_SPARE);
    r.idx = 10'h3FF;
    send_req(r);
    load_slot(1023, 1'b1, pack_name("BOGUS"), 100, 2);
    read_file('1, 23'h7FFFFF, 23'h7FFFFF);
    drain();
  endtask

  // hand-built files covering each corner of the walk
  task automatic test_directed();
    set_mount(1'b1);
    read_file(pack_name("A"), 10, 0);               // empty directory
    load_link(5, 6);
    load_link(6, 7);
    load_link(7, END_MARK);
    load_link(8, END_MARK);
    load_link(20, 21);
    load_link(21, 20);                              // loop for the segment cap
    load_link(1023, 10'h3FF);
    load_slot(0, 1'b1, pack_name("A"), 10000, 5);
    load_slot(1, 1'b1, 48'hCAFE_BE00_4342, 5000, 8); // garbage after the zero byte
    load_slot(2, 1'b0, pack_name("GHOST"), 100, 5);
    load_slot(3, 1'b1, pack_name("EMPTY"), 0, 5);
    load_slot(4, 1'b1, pack_name("ENDB"), 100, END_MARK);
    load_slot(5, 1'b1, pack_name("LOOP"), 4194304, 20);
    load_slot(6, 1'b1, pack_name("SHORT"), 20000, 8);
    load_slot(255, 1'b1, '1, 23'h7FFFFF, 1023);
    read_file(pack_name("A"), 10000, 0);
    read_file(pack_name("A"), 23'h7FFFFF, 5000);   // clamped to file end
    read_file(pack_name("A"), 50, 10000);          // offset at the end
    read_file(pack_name("A"), 50, 10001);          // offset past the end
    read_file(pack_name("A"), 0, 0);
    read_file(48'h1111_2200_4342, 6000, 100);      // prefix match up to the zero
    read_file(pack_name("GHOST"), 10, 0);          // unused slot
    read_file(pack_name("NONE"), 10, 0);
    read_file(pack_name("EMPTY"), 10, 0);
    read_file(pack_name("ENDB"), 10, 0);           // first block ends the chain
    read_file(pack_name("SHORT"), 100, 12000);     // chain ends while skipping
    read_file(pack_name("LOOP"), 4194304, 0);      // segment cap
    read_file(pack_name("LOOP"), 100, 4190000);    // long skip
    read_file('1, 23'h7FFFFF, 0);
    drain();
  endtask

  function automatic logic [47:0] pool_name(int unsigned k);
    logic [47:0] v;
    v = '0;
    v[7:0] = 8'h41 + k[7:0];
    if (k[0]) v[15:8] = 8'h30 + k[7:0];
    // random bytes beyond the terminating zero
    v[47:24] = $urandom_range(0, 1) ? $urandom : 24'h0;
    return v;
  endfunction

  task automatic test_random();
    int unsigned pick, len, off, sz;
    req_t r;
    for (int n = 0; n < 200; n++) begin
      calm = (n >= 100 && n < 160);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        if ($urandom_range(0, 9) == 0) load_link($urandom_range(0, 1023), $urandom_range(0, 1023));
        else load_link($urandom_range(0, 63),
                       ($urandom_range(0, 3) == 0) ? END_MARK : $urandom_range(0, 63));
      end else if (pick < 35) begin
        sz = ($urandom_range(0, 9) == 0) ? ($urandom & 23'h7FFFFF) : $urandom_range(0, 40000);
        if ($urandom_range(0, 9) == 0)
          load_slot($urandom_range(0, 1023), $urandom_range(0, 1),
                    {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, sz, $urandom_range(0, 1023));
        else
          load_slot($urandom_range(0, 15), $urandom_range(0, 4) != 0,
                    pool_name($urandom_range(0, 7)), sz, $urandom_range(0, 63));
      end else if (pick < 95) begin
        len = ($urandom_range(0, 9) == 0) ? ($urandom & 23'h7FFFFF) : $urandom_range(0, 20000);
        off = ($urandom_range(0, 9) == 0) ? ($urandom & 23'h7FFFFF) : $urandom_range(0, 30000);
        if ($urandom_range(0, 19) == 0)
          read_file({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, len, off);
        else
          read_file(pool_name($urandom_range(0, 8)), len, off);
      end else begin
        r = blank_req(FUNC_SPARE);
        r.idx  = $urandom;
        r.name = {$urandom, $urandom};
        send_req(r);
      end
    end
    calm = 1'b0;
    drain();
  endtask

  // unmount and mount again with the tables still loaded
  task automatic test_remount();
    set_mount(1'b0);
    read_file(pack_name("A"), 100, 0);
    read_file(pack_name("LOOP"), 100, 0);
    drain();
    set_mount(1'b1);
    read_file(pack_name("A"), 100, 4000);
    read_file(pack_name("LOOP"), 9000, 4095);
    drain();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    calm               = 1'b0;
    mismatches         = 0;
    n_items            = 0;
    n_reads            = 0;
    n_segs             = 0;
    n_errs             = 0;
    mount_q            = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_CHAIN;
    req_if.entry_index = '0;
    req_if.chain_next  = '0;
    req_if.slot_used   = 1'b0;
    req_if.file_name   = '0;
    req_if.file_size   = '0;
    req_if.start_block = '0;
    req_if.read_length = '0;
    req_if.read_offset = '0;
    res_if.ready       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_unmounted();
    test_directed();
    test_random();
    test_remount();

    drain();
    $display("%0d requests sent, %0d reads: %0d segments and %0d status results checked",
             n_items, n_reads, n_segs, n_errs);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else begin
      $display("%0d mismatching results", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
